[sv/m2a_pkg.sv]
// m2a_pkg: shared types and constants for the 2x2 matrix arithmetic unit.
// Item and result structs, operation codes, pipeline depths, divider state.
// No dependencies.
package m2a_pkg;

  localparam logic [2:0] FuncAdd       = 3'd0;
  localparam logic [2:0] FuncSub       = 3'd1;
  localparam logic [2:0] FuncMatmul    = 3'd2;
  localparam logic [2:0] FuncScale     = 3'd3;
  localparam logic [2:0] FuncDivide    = 3'd4;
  localparam logic [2:0] FuncInverse   = 3'd5;
  localparam logic [2:0] FuncTranspose = 3'd6;
  localparam logic [2:0] FuncDet       = 3'd7;

  localparam int NumLanes   = 4;
  localparam int QuoBits    = 33;
  localparam int PreStages  = 4;
  localparam int PostStages = 2;
  localparam int NumStages  = PreStages + QuoBits + PostStages;

  localparam logic [64:0] QOne = 65'd65536;
  localparam logic signed [31:0] Int32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_r0c0;
    logic signed [31:0] a_r0c1;
    logic signed [31:0] a_r1c0;
    logic signed [31:0] a_r1c1;
    logic signed [31:0] b_r0c0;
    logic signed [31:0] b_r0c1;
    logic signed [31:0] b_r1c0;
    logic signed [31:0] b_r1c1;
    logic signed [31:0] scalar;
  } m2a_in_t;

  typedef struct packed {
    logic signed [31:0] r_r0c0;
    logic signed [31:0] r_r0c1;
    logic signed [31:0] r_r1c0;
    logic signed [31:0] r_r1c1;
    logic               overflow_flag;
  } m2a_out_t;

  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        den;
    logic [QuoBits-1:0] quo;
    logic               neg;
    logic               dz;
    logic               sat;
  } m2a_div_t;

endpackage

[sv/m2a_div_step.sv]
// m2a_div_step: one registered restoring-division step, one quotient bit.
// Depends on m2a_pkg (m2a_div_t, QuoBits).
module m2a_div_step #(
  parameter int Shift = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  m2a_pkg::m2a_div_t div_i,
  output m2a_pkg::m2a_div_t div_o
);

  localparam logic [m2a_pkg::QuoBits-1:0] Bit =
    {{(m2a_pkg::QuoBits-1){1'b0}}, 1'b1} << Shift;

  logic [96:0]       dsh;
  logic              ge;
  m2a_pkg::m2a_div_t div_d, div_q;

  always_comb begin
    dsh   = {33'b0, div_i.den} << Shift;
    ge    = {33'b0, div_i.rem} >= dsh;
    div_d = div_i;
    if (ge) begin
      div_d.rem = div_i.rem - dsh[63:0];
      div_d.quo = div_i.quo | Bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[sv/m2a_lane.sv]
// m2a_lane: datapath for one result element: multiply, combine, 33-step
// divider, rounding and saturation. Depends on m2a_pkg and m2a_div_step.
module m2a_lane #(
  parameter int Lane = 0
) (
  input  logic                               clk_i,
  input  logic [m2a_pkg::NumStages-1:0]      en_i,
  input  m2a_pkg::m2a_in_t                   in_data_i,
  output logic signed [31:0]                 res_o,
  output logic                               ovf_o
);

  localparam int Row    = Lane / 2;
  localparam int Col    = Lane % 2;
  localparam int TrIdx  = (Lane == 1) ? 2 : ((Lane == 2) ? 1 : Lane);
  localparam int InvIdx = ((Lane == 1) || (Lane == 2)) ? Lane : 3 - Lane;
  localparam bit InvNeg = (Lane == 1) || (Lane == 2);
  localparam int RndSt  = m2a_pkg::PreStages + m2a_pkg::QuoBits;

  logic signed [31:0] a [4];
  logic signed [31:0] b [4];

  assign a[0] = in_data_i.a_r0c0;
  assign a[1] = in_data_i.a_r0c1;
  assign a[2] = in_data_i.a_r1c0;
  assign a[3] = in_data_i.a_r1c1;
  assign b[0] = in_data_i.b_r0c0;
  assign b[1] = in_data_i.b_r0c1;
  assign b[2] = in_data_i.b_r1c0;
  assign b[3] = in_data_i.b_r1c1;

  // multiply
  logic signed [31:0] x1, y1, x2, y2;
  logic signed [32:0] e_d;
  logic signed [63:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [32:0] e_q;
  logic signed [31:0] s_q;
  logic [2:0]         func_q;

  always_comb begin
    x1  = '0;
    y1  = '0;
    x2  = '0;
    y2  = '0;
    e_d = '0;
    unique case (in_data_i.func)
      m2a_pkg::FuncAdd:    e_d = {a[Lane][31], a[Lane]} + {b[Lane][31], b[Lane]};
      m2a_pkg::FuncSub:    e_d = {a[Lane][31], a[Lane]} - {b[Lane][31], b[Lane]};
      m2a_pkg::FuncMatmul: begin
        x1 = a[Row*2];
        y1 = b[Col];
        x2 = a[Row*2+1];
        y2 = b[2+Col];
      end
      m2a_pkg::FuncScale: begin
        x1 = a[Lane];
        y1 = in_data_i.scalar;
      end
      m2a_pkg::FuncDivide: e_d = {a[Lane][31], a[Lane]};
      m2a_pkg::FuncInverse: begin
        x1  = a[0];
        y1  = a[3];
        x2  = a[1];
        y2  = a[2];
        e_d = InvNeg ? -{a[InvIdx][31], a[InvIdx]} : {a[InvIdx][31], a[InvIdx]};
      end
      m2a_pkg::FuncTranspose: e_d = {a[TrIdx][31], a[TrIdx]};
      m2a_pkg::FuncDet: begin
        x1 = a[0];
        y1 = a[3];
        x2 = a[1];
        y2 = a[2];
      end
      default: e_d = '0;
    endcase
  end

  assign p1_d = x1 * y1;
  assign p2_d = x2 * y2;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      e_q    <= e_d;
      s_q    <= in_data_i.scalar;
      func_q <= in_data_i.func;
    end
  end

  // combine: numerator and denominator
  logic [64:0] sum_add, sum_sub, v_d, d_d, v_q, d_q;
  logic        dz_d, dz_q;
  logic [64:0] e_ext, s_ext;

  assign sum_add = {p1_q[63], p1_q} + {p2_q[63], p2_q};
  assign sum_sub = {p1_q[63], p1_q} - {p2_q[63], p2_q};
  assign e_ext   = {{32{e_q[32]}}, e_q};
  assign s_ext   = {{33{s_q[31]}}, s_q};

  always_comb begin
    v_d  = e_ext;
    d_d  = 65'd1;
    dz_d = 1'b0;
    unique case (func_q)
      m2a_pkg::FuncMatmul, m2a_pkg::FuncScale: begin
        v_d = sum_add;
        d_d = m2a_pkg::QOne;
      end
      m2a_pkg::FuncDivide: begin
        v_d  = {{16{e_q[32]}}, e_q, 16'b0};
        d_d  = s_ext;
        dz_d = (s_q == '0);
      end
      m2a_pkg::FuncInverse: begin
        v_d  = {e_q, 32'b0};
        d_d  = sum_sub;
        dz_d = (sum_sub == '0);
      end
      m2a_pkg::FuncDet: begin
        v_d = (Lane == 0) ? sum_sub : '0;
        d_d = (Lane == 0) ? m2a_pkg::QOne : 65'd1;
      end
      default: begin
        v_d = e_ext;
        d_d = 65'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      v_q  <= v_d;
      d_q  <= d_d;
      dz_q <= dz_d;
    end
  end

  // magnitudes and sign
  logic [64:0]       v_mag, d_mag;
  m2a_pkg::m2a_div_t mag_d, mag_q, chk_d;
  m2a_pkg::m2a_div_t chain [m2a_pkg::QuoBits+1];

  assign v_mag = v_q[64] ? (~v_q + 65'd1) : v_q;
  assign d_mag = d_q[64] ? (~d_q + 65'd1) : d_q;

  always_comb begin
    mag_d.rem = v_mag[63:0];
    mag_d.den = d_mag[63:0];
    mag_d.quo = '0;
    mag_d.neg = v_q[64] ^ d_q[64];
    mag_d.dz  = dz_q;
    mag_d.sat = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      mag_q <= mag_d;
    end
  end

  // quotient too large for the divider range
  always_comb begin
    chk_d     = mag_q;
    chk_d.sat = {33'b0, mag_q.rem} >= {mag_q.den, 33'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      chain[0] <= chk_d;
    end
  end

  for (genvar j = 0; j < m2a_pkg::QuoBits; j++) begin : g_div
    m2a_div_step #(
      .Shift(m2a_pkg::QuoBits - 1 - j)
    ) u_step (
      .clk_i(clk_i),
      .en_i (en_i[m2a_pkg::PreStages + j]),
      .div_i(chain[j]),
      .div_o(chain[j+1])
    );
  end

  // round to nearest, ties away from zero
  m2a_pkg::m2a_div_t fin;
  logic [m2a_pkg::QuoBits-1:0] quo_q;
  logic rnd_q, neg_q, dzf_q, sat_q, zr_q;

  assign fin = chain[m2a_pkg::QuoBits];

  always_ff @(posedge clk_i) begin
    if (en_i[RndSt]) begin
      quo_q <= fin.quo;
      rnd_q <= {fin.rem, 1'b0} >= {1'b0, fin.den};
      neg_q <= fin.neg;
      dzf_q <= fin.dz;
      sat_q <= fin.sat;
      zr_q  <= (fin.rem == '0);
    end
  end

  // saturate
  logic [m2a_pkg::QuoBits:0] q_rnd;
  logic signed [31:0]        res_d, res_q;
  logic                      ovf_d, ovf_q;

  assign q_rnd = {1'b0, quo_q} + {{m2a_pkg::QuoBits{1'b0}}, rnd_q};

  always_comb begin
    res_d = '0;
    ovf_d = 1'b0;
    priority if (dzf_q) begin
      ovf_d = 1'b1;
      res_d = zr_q ? '0 : (neg_q ? m2a_pkg::Int32Min : m2a_pkg::Int32Max);
    end else if (sat_q) begin
      ovf_d = 1'b1;
      res_d = neg_q ? m2a_pkg::Int32Min : m2a_pkg::Int32Max;
    end else if (neg_q) begin
      if (q_rnd >= 34'h0_8000_0000) begin
        res_d = m2a_pkg::Int32Min;
        ovf_d = (q_rnd > 34'h0_8000_0000);
      end else begin
        res_d = ~q_rnd[31:0] + 32'd1;
      end
    end else begin
      if (q_rnd > 34'h0_7fff_ffff) begin
        res_d = m2a_pkg::Int32Max;
        ovf_d = 1'b1;
      end else begin
        res_d = q_rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[RndSt+1]) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

[sv/matrix2x2_alu_unit.sv]
// matrix2x2_alu_unit: top level of the 2x2 matrix arithmetic unit.
// Depends on m2a_pkg and m2a_lane.
//
// One item per cycle, sustained while out_ready_i is high or any stage is
// empty. Four lanes each compute one result element in
// Q16.16; the depth is set by the per-lane divider, a 33-stage restoring
// pipeline shared by every operation. Each stage holds its item until the
// next one frees up, so bubbles collapse and input keeps flowing while a
// result waits at the output. The overflow flag is the OR of the lane flags.
module matrix2x2_alu_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  m2a_pkg::m2a_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output m2a_pkg::m2a_out_t out_data_o
);

  localparam int N = m2a_pkg::NumStages;

  logic [N-1:0] vld_q;
  logic [N-1:0] en;

  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&vld_q[N-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  logic signed [31:0] res [m2a_pkg::NumLanes];
  logic [m2a_pkg::NumLanes-1:0] ovf;

  for (genvar l = 0; l < m2a_pkg::NumLanes; l++) begin : g_lane
    m2a_lane #(
      .Lane(l)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .in_data_i(in_data_i),
      .res_o    (res[l]),
      .ovf_o    (ovf[l])
    );
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[N-1];

  assign out_data_o.r_r0c0        = res[0];
  assign out_data_o.r_r0c1        = res[1];
  assign out_data_o.r_r1c0        = res[2];
  assign out_data_o.r_r1c1        = res[3];
  assign out_data_o.overflow_flag = |ovf;

endmodule
